### hw/rtl/tla_pkg.sv
// ----------------------------------------------------------------------------
// tla_pkg
// Shared types and constants of the toroidal Life automaton: command codes,
// field widths, and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
`default_nettype none

package tla_pkg;

    // Widths of the item fields and of the side register.
    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int SIDE_W  = 7;

    // Side length after reset.
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

    // Neighbor counts of the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Command codes of an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // latch the incoming item
        logic rd_cell;    // read the front row that holds the addressed cell
        logic cell_op;    // apply set, clear or read to the row just read
        logic step_init;  // clear the back board and the row counter
        logic step_rd;    // read the next row of the generation sweep
        logic swap;       // exchange front and back boards
        logic res_load;   // load the result register
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_step;    // latched item is a step command
        logic oor;        // latched coordinate lies outside the active square
        logic rd_last;    // current sweep read is the last one
    } t_sts;

endpackage

`default_nettype wire

### hw/rtl/tla_in_if.sv
// ----------------------------------------------------------------------------
// tla_in_if
// Command channel: valid/ready handshake carrying cmd, x and y.
// ----------------------------------------------------------------------------
`default_nettype none

interface tla_in_if;
    logic                        valid;
    logic                        ready;
    logic [tla_pkg::CMD_W-1:0]   cmd;
    logic [tla_pkg::COORD_W-1:0] x;
    logic [tla_pkg::COORD_W-1:0] y;

    modport source (output valid, output cmd, output x, output y, input ready);
    modport sink   (input valid, input cmd, input x, input y, output ready);
endinterface

`default_nettype wire

### hw/rtl/tla_out_if.sv
// ----------------------------------------------------------------------------
// tla_out_if
// Result channel: valid/ready handshake carrying status and cell_value.
// ----------------------------------------------------------------------------
`default_nettype none

interface tla_out_if;
    logic valid;
    logic ready;
    logic status;
    logic cell_value;

    modport source (output valid, output status, output cell_value, input ready);
    modport sink   (input valid, input status, input cell_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/toroidal_life_automaton_unit.sv
// ----------------------------------------------------------------------------
// toroidal_life_automaton_unit
// Conway Life (B3/S23) on a wrapping square board with double buffering.
// ----------------------------------------------------------------------------
// Each command item returns exactly one result item. Set, clear and read act
// on one cell of the front board: the item is decoded, the row that holds
// the cell is read and, for set or clear, written back, and the result
// register is loaded once the result channel can take it. An out-of-range
// coordinate skips the cell access, and a coordinate at or beyond the side
// gives status 1. A step sweeps the front board one row per cycle through
// the single read port of the board memory, reading side plus two rows (the
// last row, every row, then row 0 again for the wrap), writes the last row,
// swaps the boards and then loads its result. Rows beyond the side come out
// dead. The board memory is cleared at reset through per-row valid bits, so
// no clearing pass is needed. A new item is accepted at the edge after the
// previous result is loaded into the result register.
`default_nettype none

module toroidal_life_automaton_unit #(
    parameter int MAX_SIDE = 64
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [tla_pkg::SIDE_W-1:0] i_cfg_wdata,
    tla_in_if.sink                    i_in,
    tla_out_if.source                 o_out
);

    tla_pkg::t_ctl ctl;
    tla_pkg::t_sts sts;

    // Controller.
    tla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    // Datapath.
    tla_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (i_in.cmd),
        .i_x          (i_in.x),
        .i_y          (i_in.y),
        .o_status     (o_out.status),
        .o_cell_value (o_out.cell_value)
    );

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.res_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten");

    // Cell updates only happen for in-range, non-step items.
    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.cell_op |-> (!sts.oor && !sts.is_step))
        else $error("cell operation on out-of-range or step item");

    // The block is never ready again right after accepting an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while previous one in progress");

endmodule

`default_nettype wire

### hw/rtl/tla_ctrl.sv
// ----------------------------------------------------------------------------
// tla_ctrl
// Controller of the Life automaton. Sequences cell commands and the
// row-by-row generation sweep, and owns the result channel's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_out_ready,
    output logic               o_out_valid,
    input  wire tla_pkg::t_sts i_sts,
    output tla_pkg::t_ctl      o_ctl
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_CELL     = 6'b000100,
        S_STEP     = 6'b001000,
        S_STEP_END = 6'b010000,
        S_RESP     = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_step) begin
                    o_ctl.step_init = 1'b1;
                    n_state         = S_STEP;
                end else if (i_sts.oor) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.rd_cell = 1'b1;
                    n_state       = S_CELL;
                end
            end
            S_CELL: begin
                o_ctl.cell_op = 1'b1;
                n_state       = S_RESP;
            end
            S_STEP: begin
                o_ctl.step_rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_STEP_END;
                end
            end
            S_STEP_END: begin
                // The last row is written at this edge, as the boards swap.
                o_ctl.swap = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (!r_out_vld || i_out_ready) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag: set on load, cleared when the item is taken.
    always_comb begin
        n_out_vld = r_out_vld;
        if (o_ctl.res_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

### hw/rtl/tla_dpath.sv
// ----------------------------------------------------------------------------
// tla_dpath
// Datapath of the Life automaton: side register, item latch, the board
// memory holding both boards row by row, the three-row window and the
// next-row logic of the generation sweep, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tla_dpath #(
    parameter int MAX_SIDE = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire tla_pkg::t_ctl           i_ctl,
    output tla_pkg::t_sts                o_sts,
    input  wire                          i_cfg_we,
    input  wire [tla_pkg::SIDE_W-1:0]    i_cfg_wdata,
    input  wire [tla_pkg::CMD_W-1:0]     i_cmd,
    input  wire [tla_pkg::COORD_W-1:0]   i_x,
    input  wire [tla_pkg::COORD_W-1:0]   i_y,
    output logic                         o_status,
    output logic                         o_cell_value
);

    localparam int RW    = $clog2(MAX_SIDE);
    localparam int AW    = RW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int HALF  = DEPTH / 2;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int KW    = $clog2(MAX_SIDE + 2);

    // Side register and latched item.
    logic [tla_pkg::SIDE_W-1:0]  r_side;
    tla_pkg::t_cmd               r_cmd;
    logic [tla_pkg::COORD_W-1:0] r_x;
    logic [tla_pkg::COORD_W-1:0] r_y;

    // Board memory: address is {board, row}; valid bits make unwritten rows dead.
    logic [MAX_SIDE-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    r_row_vld;
    logic [MAX_SIDE-1:0] r_rd_data;
    logic                r_rd_vld;
    logic [MAX_SIDE-1:0] rd_row;
    logic                r_front;

    // Sweep state.
    logic [KW-1:0]       r_k;
    logic                r_arr_vld;
    logic [KW-1:0]       r_arr_k;
    logic [MAX_SIDE-1:0] r_up;
    logic [MAX_SIDE-1:0] r_mid;
    logic [MAX_SIDE-1:0] next_row;

    // Result.
    logic                r_cell_bit;
    logic                r_res_status;
    logic                r_res_cell;

    logic [SW-1:0]       s;
    logic [RW-1:0]       col;
    logic [RW-1:0]       row;
    logic [RW-1:0]       sweep_row;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MAX_SIDE-1:0] wr_data;

    // Active side, with zero taken as one and large values as MAX_SIDE.
    always_comb begin
        if (r_side == '0) begin
            s = SW'(1);
        end else if (32'(r_side) > 32'(MAX_SIDE)) begin
            s = SW'(MAX_SIDE);
        end else begin
            s = SW'(r_side);
        end
    end

    assign col = RW'(r_x);
    assign row = RW'(r_y);

    // Status toward the controller.
    assign o_sts.is_step = (r_cmd == tla_pkg::CMD_STEP);
    assign o_sts.oor     = (32'(r_x) >= 32'(s)) || (32'(r_y) >= 32'(s));
    assign o_sts.rd_last = (r_k == (KW'(s) + KW'(1)));

    // Sweep read order: last row, rows 0 to side-1, then row 0 again.
    always_comb begin
        if (r_k == '0) begin
            sweep_row = RW'(s - SW'(1));
        end else if (o_sts.rd_last) begin
            sweep_row = '0;
        end else begin
            sweep_row = RW'(r_k - KW'(1));
        end
    end

    // Read port: cell commands and the sweep both read the front board.
    assign rd_en   = i_ctl.rd_cell || i_ctl.step_rd;
    assign rd_addr = i_ctl.rd_cell ? {r_front, row} : {r_front, sweep_row};
    assign rd_row  = r_rd_vld ? r_rd_data : '0;

    // Next generation of the middle row of the window, wrapped at the side.
    always_comb begin
        int         cl;
        int         cr;
        logic [3:0] n;
        next_row = '0;
        for (int c = 0; c < MAX_SIDE; c++) begin
            cl = (c == 0) ? (int'(s) - 1) : (c - 1);
            cr = ((c + 1) < int'(s)) ? (c + 1) : 0;
            n  = 4'(r_up[RW'(cl)])   + 4'(r_up[RW'(c)])   + 4'(r_up[RW'(cr)])
               + 4'(r_mid[RW'(cl)])                       + 4'(r_mid[RW'(cr)])
               + 4'(rd_row[RW'(cl)]) + 4'(rd_row[RW'(c)]) + 4'(rd_row[RW'(cr)]);
            if (c < int'(s)) begin
                if (r_mid[c]) begin
                    next_row[c] = (n == tla_pkg::SURVIVE_COUNT) ||
                                  (n == tla_pkg::BIRTH_COUNT);
                end else begin
                    next_row[c] = (n == tla_pkg::BIRTH_COUNT);
                end
            end
        end
    end

    // Write port: set or clear on the front board, or a swept row on the back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_front, row};
        wr_data = rd_row;
        if (r_arr_vld && (r_arr_k >= KW'(2))) begin
            wr_en   = 1'b1;
            wr_addr = {~r_front, RW'(r_arr_k - KW'(2))};
            wr_data = next_row;
        end else if (i_ctl.cell_op && (r_cmd == tla_pkg::CMD_SET)) begin
            wr_en        = 1'b1;
            wr_data[col] = 1'b1;
        end else if (i_ctl.cell_op && (r_cmd == tla_pkg::CMD_CLEAR)) begin
            wr_en        = 1'b1;
            wr_data[col] = 1'b0;
        end
    end

    // Board memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Control registers: side, front select, row valid bits, sweep counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= tla_pkg::SIDE_RESET;
            r_front   <= 1'b0;
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_k       <= '0;
            r_arr_vld <= 1'b0;
            r_arr_k   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
            end
            // A new sweep drops every row of the back board at once.
            if (i_ctl.step_init) begin
                if (r_front) begin
                    r_row_vld <= {r_row_vld[DEPTH-1:HALF], {HALF{1'b0}}};
                end else begin
                    r_row_vld <= {{HALF{1'b0}}, r_row_vld[HALF-1:0]};
                end
            end else if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
            if (i_ctl.step_init) begin
                r_k <= '0;
            end else if (i_ctl.step_rd) begin
                r_k <= r_k + KW'(1);
            end
            r_arr_vld <= i_ctl.step_rd;
            r_arr_k   <= r_k;
            if (i_ctl.swap) begin
                r_front <= ~r_front;
            end
        end
    end

    // Payload registers: item latch, row window, read bit, result.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd <= tla_pkg::t_cmd'(i_cmd);
            r_x   <= i_x;
            r_y   <= i_y;
        end
        if (r_arr_vld) begin
            r_up  <= r_mid;
            r_mid <= rd_row;
        end
        if (i_ctl.cell_op) begin
            r_cell_bit <= rd_row[col];
        end
        if (i_ctl.res_load) begin
            r_res_status <= o_sts.oor && !o_sts.is_step;
            r_res_cell   <= (r_cmd == tla_pkg::CMD_READ) && !o_sts.oor && r_cell_bit;
        end
    end

    assign o_status     = r_res_status;
    assign o_cell_value = r_res_cell;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the toroidal Life automaton unit. It drives
// command items (set, clear, read, step) through the input channel, keeps
// its own mirror of both boards and of the side register, and checks every
// result item against the mirror in order. It covers corner cells,
// coordinates out of range, the degenerate sides 0, 1 and 2, sides above
// the maximum, gliders that wrap around the torus, and random idling on
// both channels with one long stall of the result channel.
// ----------------------------------------------------------------------------

module tb;
    import tla_pkg::*;

    localparam int BOARD_MAX    = 64;
    localparam int TOTAL_ITEMS  = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_SETTLE  = 8;
    localparam int END_SETTLE   = 80;

    // Status and cell value of one result item.
    typedef struct packed {
        bit status;
        bit cell_value;
    } cell_reply_t;

    // Mirror of both boards and the side register, with the queue of
    // result items that are still due from the block.
    class life_board_mirror;
        bit [BOARD_MAX-1:0] cells [2][BOARD_MAX];
        bit                 front_sel;
        bit [SIDE_W-1:0]    side_reg;
        cell_reply_t        awaited_results [$];
        int unsigned        error_count;

        function new();
            front_sel   = 1'b0;
            side_reg    = SIDE_RESET;
            error_count = 0;
        endfunction

        function void set_side(bit [SIDE_W-1:0] value);
            side_reg = value;
        endfunction

        // A side of 0 acts as 1, and anything above the maximum as the maximum.
        function int unsigned live_side();
            if (side_reg == 0) return 1;
            if (side_reg > BOARD_MAX) return BOARD_MAX;
            return side_reg;
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction

        // Compute the next generation into the back board, then swap.
        // Cells outside the active square come out dead.
        function void evolve();
            int unsigned s, r, c, xl, xr, yu, yd, n;
            bit          f;
            f = front_sel;
            s = live_side();
            for (r = 0; r < BOARD_MAX; r++) begin
                cells[~f][r] = '0;
                if (r < s) begin
                    for (c = 0; c < s; c++) begin
                        xl = (c > 0) ? c - 1 : s - 1;
                        xr = (c + 1 < s) ? c + 1 : 0;
                        yu = (r > 0) ? r - 1 : s - 1;
                        yd = (r + 1 < s) ? r + 1 : 0;
                        // Wrapped positions may repeat on tiny boards; each counts.
                        n = cells[f][yu][xl] + cells[f][yu][xr]
                          + cells[f][yd][xl] + cells[f][yd][xr]
                          + cells[f][r][xl]  + cells[f][r][xr]
                          + cells[f][yu][c]  + cells[f][yd][c];
                        if (cells[f][r][c]) begin
                            cells[~f][r][c] = (n == SURVIVE_COUNT) || (n == BIRTH_COUNT);
                        end else begin
                            cells[~f][r][c] = (n == BIRTH_COUNT);
                        end
                    end
                end
            end
            front_sel = ~f;
        endfunction

        // Apply one accepted command item and queue the result it causes.
        function void note_command(t_cmd cmd, bit [COORD_W-1:0] x, bit [COORD_W-1:0] y);
            cell_reply_t want;
            int unsigned s;
            want = '0;
            s    = live_side();
            if (cmd == CMD_STEP) begin
                evolve();
            end else if (x >= s || y >= s) begin
                want.status = 1'b1;
            end else begin
                case (cmd)
                    CMD_SET:   cells[front_sel][y][x] = 1'b1;
                    CMD_CLEAR: cells[front_sel][y][x] = 1'b0;
                    default:   want.cell_value = cells[front_sel][y][x];
                endcase
            end
            awaited_results.push_back(want);
        endfunction

        function void report(string msg);
            error_count++;
            if (error_count <= 10) $display("%0t ns: %s", $time, msg);
        endfunction

        // Compare one accepted result item with the oldest one due.
        function void check_result(logic status, logic cell_value);
            cell_reply_t want;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result item: status %b cell_value %b",
                                 status, cell_value));
                return;
            end
            want = awaited_results.pop_front();
            if (status !== want.status)
                report($sformatf("status mismatch: expected %b, got %b",
                                 want.status, status));
            if (cell_value !== want.cell_value)
                report($sformatf("cell_value mismatch: expected %b, got %b",
                                 want.cell_value, cell_value));
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [SIDE_W-1:0] cfg_wdata;

    tla_in_if  in_ch ();
    tla_out_if out_ch ();

    life_board_mirror board_mirror = new();

    // Idling controls shared between the command and result sides.
    int unsigned gap_odds   = 0;
    int unsigned stall_odds = 0;
    bit          hold_request = 1'b0;
    int unsigned items_sent = 0;

    toroidal_life_automaton_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Clock with a 12 ns period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check accepted items, stall at random, and serve one long
    // hold-off on request so that the block backs up into the command side.
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left   = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                board_mirror.check_result(out_ch.status, out_ch.cell_value);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic bit [COORD_W-1:0] rand_coord(int unsigned limit);
        return COORD_W'($urandom_range(0, limit - 1));
    endfunction

    // Offer one command item, with an optional idle gap first, and wait
    // until the block accepts it.
    task automatic send_item(t_cmd cmd, bit [COORD_W-1:0] x, bit [COORD_W-1:0] y);
        int unsigned gap;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.x     <= x;
        in_ch.y     <= y;
        do @(posedge clk); while (!in_ch.ready);
        board_mirror.note_command(cmd, x, y);
        items_sent++;
    endtask

    // Stop offering items and wait until every result item has come back.
    task automatic drain(int unsigned settle);
        in_ch.valid <= 1'b0;
        while (board_mirror.outstanding() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the side register; only done once the block is idle.
    task automatic write_side(bit [SIDE_W-1:0] value);
        drain(IDLE_SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board_mirror.set_side(value);
    endtask

    // Corner cells, out-of-range coordinates and the one-cell board.
    task automatic directed_items();
        send_item(CMD_READ,  6'd0,  6'd0);
        send_item(CMD_SET,   6'd0,  6'd0);
        send_item(CMD_SET,   6'd63, 6'd63);
        send_item(CMD_SET,   6'd63, 6'd0);
        send_item(CMD_SET,   6'd0,  6'd63);
        send_item(CMD_READ,  6'd63, 6'd63);
        send_item(CMD_READ,  6'd0,  6'd63);
        // The four corners are neighbors across the wrap and survive.
        send_item(CMD_STEP,  6'd0,  6'd0);
        send_item(CMD_READ,  6'd0,  6'd0);
        send_item(CMD_CLEAR, 6'd63, 6'd63);
        send_item(CMD_READ,  6'd63, 6'd63);
        send_item(CMD_CLEAR, 6'd5,  6'd5);
        send_item(CMD_STEP,  6'd63, 6'd63);
        send_item(CMD_READ,  6'd0,  6'd0);
        write_side(7'd4);
        send_item(CMD_SET,   6'd4,  6'd0);
        send_item(CMD_SET,   6'd0,  6'd4);
        send_item(CMD_CLEAR, 6'd63, 6'd63);
        send_item(CMD_READ,  6'd63, 6'd0);
        send_item(CMD_SET,   6'd3,  6'd3);
        send_item(CMD_READ,  6'd3,  6'd3);
        send_item(CMD_STEP,  6'd0,  6'd0);
        // On a one-cell board a live cell counts itself eight times and dies.
        write_side(7'd1);
        send_item(CMD_SET,   6'd0,  6'd0);
        send_item(CMD_STEP,  6'd0,  6'd0);
        send_item(CMD_READ,  6'd0,  6'd0);
        send_item(CMD_SET,   6'd1,  6'd0);
    endtask

    // Side of each random phase: the extremes first, then mostly small boards.
    function automatic bit [SIDE_W-1:0] pick_side(int unsigned phase);
        case (phase)
            0: return 7'd2;
            1: return 7'd3;
            2: return 7'd6;
            3: return 7'd64;
            4: return 7'd0;
            5: return 7'd127;
            6: return 7'd65;
            default: begin
                case ($urandom_range(0, 19))
                    0:       return 7'd64;
                    1:       return SIDE_W'($urandom_range(17, 63));
                    2:       return SIDE_W'($urandom_range(65, 127));
                    3:       return SIDE_W'($urandom_range(0, 2));
                    default: return SIDE_W'($urandom_range(3, 12));
                endcase
            end
        endcase
    endfunction

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return 5;
            default: return 12;
        endcase
    endfunction

    // Seed a pattern, then mix steps with reads, edits and stray coordinates.
    task automatic run_phase(int unsigned count);
        int unsigned glider_x [5] = '{1, 2, 0, 1, 2};
        int unsigned glider_y [5] = '{0, 1, 2, 2, 2};
        int unsigned s, seeds, k, i, pick, ox, oy;
        s = board_mirror.live_side();
        k = 0;
        // A glider at a random spot travels across the wrapped edges.
        if (s >= 3 && $urandom_range(0, 1) == 1) begin
            ox = $urandom_range(0, s - 1);
            oy = $urandom_range(0, s - 1);
            for (i = 0; i < 5; i++) begin
                send_item(CMD_SET, COORD_W'((ox + glider_x[i]) % s),
                          COORD_W'((oy + glider_y[i]) % s));
                k++;
            end
        end
        seeds = $urandom_range(0, (s * s < 12) ? s * s : 12);
        for (i = 0; i < seeds; i++) begin
            send_item(CMD_SET, rand_coord(s), rand_coord(s));
            k++;
        end
        while (k < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                send_item(CMD_STEP, rand_coord(BOARD_MAX), rand_coord(BOARD_MAX));
            end else if (pick < 52) begin
                send_item(CMD_READ, rand_coord(s), rand_coord(s));
            end else if (pick < 64) begin
                send_item(CMD_SET, rand_coord(s), rand_coord(s));
            end else if (pick < 72) begin
                send_item(CMD_CLEAR, rand_coord(s), rand_coord(s));
            end else if (pick < 92) begin
                // Cell commands anywhere on the full coordinate range.
                case ($urandom_range(0, 2))
                    0:       send_item(CMD_SET, rand_coord(BOARD_MAX), rand_coord(BOARD_MAX));
                    1:       send_item(CMD_CLEAR, rand_coord(BOARD_MAX),
                                       rand_coord(BOARD_MAX));
                    default: send_item(CMD_READ, rand_coord(BOARD_MAX), rand_coord(BOARD_MAX));
                endcase
            end else begin
                send_item(t_cmd'($urandom_range(0, 3)), rand_coord(BOARD_MAX),
                          rand_coord(BOARD_MAX));
            end
            k++;
        end
    endtask

    // Reset, directed items, random phases, then the final verdict.
    initial begin : stimulus
        int unsigned phase;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd   = '0;
        in_ch.x     = '0;
        in_ch.y     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed_items();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            write_side(pick_side(phase));
            // The tail of the run goes without any idling.
            if (TOTAL_ITEMS - items_sent < 160) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = pick_odds();
                stall_odds = pick_odds();
            end
            if (phase == 2) hold_request = 1'b1;
            run_phase($urandom_range(30, 70));
            phase++;
        end

        drain(END_SETTLE);
        if (board_mirror.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
